[hw/rtl/assert_macros.svh]
// Assertion macros shared by the convex region point test RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CRPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crpt check failed");

// Clocked check that also runs through reset.
`define CRPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crpt check failed");

`endif

[hw/rtl/crpt_pkg.sv]
// Shared constants and the query token type for the convex region point test.
package crpt_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int ORG_W  = 14;
  localparam int IDX_W  = 4;
  localparam int PT_W   = 15;
  localparam int VTX_W  = 15;
  localparam int DIF_W  = 16;
  localparam int PRD_W  = 32;
  localparam int SUM_W  = 33;
  localparam int MAG_W  = 16;
  localparam int LEN_W  = 31;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_ORG_X = 2'd1;
  localparam logic [1:0] REG_ORG_Y = 2'd2;

  // One query travelling down the cell chain. The edge test is skewed over
  // three cells: products, then cross value, then the squared compare.
  typedef struct packed {
    logic                    vld;
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
    logic signed [VTX_W-1:0] pvx;
    logic signed [VTX_W-1:0] pvy;
    logic                    box_any;
    logic signed [VTX_W-1:0] mnx;
    logic signed [VTX_W-1:0] mxx;
    logic signed [VTX_W-1:0] mny;
    logic signed [VTX_W-1:0] mxy;
    logic                    pa_vld;
    logic signed [PRD_W-1:0] m1;
    logic signed [PRD_W-1:0] m2;
    logic [LEN_W-2:0]        sqx;
    logic [LEN_W-2:0]        sqy;
    logic                    pb_vld;
    logic                    neg;
    logic                    near;
    logic [MAG_W-1:0]        cmag;
    logic [LEN_W-1:0]        len;
    logic                    ok;
  } crpt_tok_t;

endpackage

[hw/rtl/crpt_cell.sv]
// One chain cell: holds a vertex, folds it into the box, runs one slice of edge tests.
module crpt_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           act,
  input  logic                           seg_act,
  input  logic                           wr_en,
  input  logic signed [crpt_pkg::VTX_W-1:0] wr_x,
  input  logic signed [crpt_pkg::VTX_W-1:0] wr_y,
  input  crpt_pkg::crpt_tok_t            tok_in,
  output crpt_pkg::crpt_tok_t            tok_out
);
  import crpt_pkg::*;

  logic signed [VTX_W-1:0] vx_r;
  logic signed [VTX_W-1:0] vy_r;
  crpt_tok_t               tok_r;
  crpt_tok_t               tok_nxt;

  logic signed [DIF_W-1:0] dx;
  logic signed [DIF_W-1:0] dy;
  logic signed [DIF_W-1:0] ex;
  logic signed [DIF_W-1:0] ey;
  logic signed [PRD_W-1:0] m1;
  logic signed [PRD_W-1:0] m2;
  logic signed [PRD_W-1:0] px2;
  logic signed [PRD_W-1:0] py2;
  logic signed [SUM_W-1:0] c;
  logic [PRD_W-1:0]        csq;
  logic                    fail;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx_r <= wr_x;
      vy_r <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  // products for the edge ending at this vertex
  assign dx  = DIF_W'(vx_r) - DIF_W'(tok_in.pvx);
  assign dy  = DIF_W'(vy_r) - DIF_W'(tok_in.pvy);
  assign ex  = DIF_W'(tok_in.px) - DIF_W'(tok_in.pvx);
  assign ey  = DIF_W'(tok_in.py) - DIF_W'(tok_in.pvy);
  assign m1  = PRD_W'(dy) * PRD_W'(ex);
  assign m2  = PRD_W'(dx) * PRD_W'(ey);
  assign px2 = PRD_W'(dx) * PRD_W'(dx);
  assign py2 = PRD_W'(dy) * PRD_W'(dy);

  // cross value of the edge one cell back
  assign c = SUM_W'(tok_in.m2) - SUM_W'(tok_in.m1);

  // squared compare of the edge two cells back; negative c with |c| >= 2^16 always fails
  assign csq  = PRD_W'(tok_in.cmag) * PRD_W'(tok_in.cmag);
  assign fail = tok_in.neg && !(tok_in.near && (csq < PRD_W'(tok_in.len)));

  always_comb begin
    tok_nxt = tok_in;

    if (tok_in.pb_vld && fail) begin
      tok_nxt.ok = 1'b0;
    end

    tok_nxt.pb_vld = tok_in.pa_vld;
    tok_nxt.neg    = c[SUM_W-1];
    tok_nxt.near   = (&c[SUM_W-1:MAG_W]) && (c[MAG_W-1:0] != '0);
    tok_nxt.cmag   = (~c[MAG_W-1:0]) + MAG_W'(1);
    tok_nxt.len    = {1'b0, tok_in.sqx} + {1'b0, tok_in.sqy};

    tok_nxt.pa_vld = seg_act;
    tok_nxt.m1     = m1;
    tok_nxt.m2     = m2;
    tok_nxt.sqx    = px2[LEN_W-2:0];
    tok_nxt.sqy    = py2[LEN_W-2:0];

    if (act) begin
      tok_nxt.pvx     = vx_r;
      tok_nxt.pvy     = vy_r;
      tok_nxt.box_any = 1'b1;
      if (tok_in.box_any) begin
        tok_nxt.mnx = (vx_r < tok_in.mnx) ? vx_r : tok_in.mnx;
        tok_nxt.mxx = (vx_r > tok_in.mxx) ? vx_r : tok_in.mxx;
        tok_nxt.mny = (vy_r < tok_in.mny) ? vy_r : tok_in.mny;
        tok_nxt.mxy = (vy_r > tok_in.mxy) ? vy_r : tok_in.mxy;
      end else begin
        tok_nxt.mnx = vx_r;
        tok_nxt.mxx = vx_r;
        tok_nxt.mny = vy_r;
        tok_nxt.mxy = vy_r;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

[hw/rtl/crpt_result.sv]
// Output stage: bounding box check, final flag and the result register.
module crpt_result (
  input  logic                clk,
  input  logic                rst_n,
  input  crpt_pkg::crpt_tok_t tail,
  input  logic                out_stall,
  output logic                adv,
  output logic                out_valid,
  output logic                out_inside_res
);
  import crpt_pkg::*;

  logic out_valid_r;
  logic inside_r;
  logic inbox;
  logic inside_nxt;

  assign inbox = (tail.px >= tail.mnx) && (tail.px <= tail.mxx) &&
                 (tail.py >= tail.mny) && (tail.py <= tail.mxy);
  assign inside_nxt = tail.box_any && inbox && tail.ok;

  // whole chain moves only when the result register can take a transfer
  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

endmodule

[hw/rtl/convex_region_point_test_core.sv]
// Convex region point test: chain of MAX_VERTICES vertex cells plus two drain cells.
// Queries stream one per cycle unless the output stalls; chain cell registers then the result register.
// A load waits until no query is left in the chain.
// Reset clears config registers and chain/result valid bits; vertex slots are undefined until loaded.
`include "assert_macros.svh"

module convex_region_point_test_core #(
  parameter int MAX_VERTICES = crpt_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [crpt_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [crpt_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [crpt_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [crpt_pkg::IDX_W-1:0]         in_vertex_index,
  input  logic signed [crpt_pkg::ORG_W-1:0]  in_vertex_x,
  input  logic signed [crpt_pkg::ORG_W-1:0]  in_vertex_y,
  input  logic signed [crpt_pkg::PT_W-1:0]   in_point_x,
  input  logic signed [crpt_pkg::PT_W-1:0]   in_point_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_inside_res
);
  import crpt_pkg::*;

  localparam int CHAIN = MAX_VERTICES + 2;

  logic [CNT_W-1:0]        count_r;
  logic signed [ORG_W-1:0] origin_x_r;
  logic signed [ORG_W-1:0] origin_y_r;
  logic                    cfg_wr;

  logic                    adv;
  logic                    accept;
  logic                    busy;
  logic                    tail_vld;
  logic signed [VTX_W-1:0] wr_x;
  logic signed [VTX_W-1:0] wr_y;
  crpt_tok_t               head;
  crpt_tok_t               tok [CHAIN+1];
  logic [CHAIN-1:0]        act;
  logic [CHAIN-1:0]        seg_act;
  logic [CHAIN-1:0]        wr_en;
  logic [CHAIN-1:0]        vld_vec;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_COUNT: count_r    <= cfg_pwdata[CNT_W-1:0];
        REG_ORG_X: origin_x_r <= cfg_pwdata[ORG_W-1:0];
        REG_ORG_Y: origin_y_r <= cfg_pwdata[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_COUNT: cfg_prdata = DATA_W'(count_r);
      REG_ORG_X: cfg_prdata = DATA_W'(origin_x_r);
      REG_ORG_Y: cfg_prdata = DATA_W'(origin_y_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // input side: loads must not overtake a query still reading the cells
  assign in_stall = !adv || (busy && (in_op == OP_LOAD));
  assign accept   = in_valid && !in_stall;

  assign wr_x = VTX_W'(in_vertex_x) + VTX_W'(origin_x_r);
  assign wr_y = VTX_W'(in_vertex_y) + VTX_W'(origin_y_r);

  always_comb begin
    head     = '0;
    head.vld = accept && (in_op == OP_QUERY);
    head.px  = in_point_x;
    head.py  = in_point_y;
    head.ok  = 1'b1;
  end

  assign tok[0] = head;

  for (genvar g = 0; g < CHAIN; g++) begin : g_cell
    assign act[g] = (g < MAX_VERTICES) && (32'(count_r) > g);
    if (g == 0) begin : g_first
      assign seg_act[g] = 1'b0;
    end else begin : g_rest
      assign seg_act[g] = act[g];
    end
    assign wr_en[g] = accept && (in_op == OP_LOAD) && (g < MAX_VERTICES) &&
                      (32'(in_vertex_index) == g);
    assign vld_vec[g] = tok[g+1].vld;

    crpt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .act     (act[g]),
      .seg_act (seg_act[g]),
      .wr_en   (wr_en[g]),
      .wr_x    (wr_x),
      .wr_y    (wr_y),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign busy     = |vld_vec;
  assign tail_vld = tok[CHAIN].vld;

  crpt_result u_result (
    .clk            (clk),
    .rst_n          (rst_n),
    .tail           (tok[CHAIN]),
    .out_stall      (out_stall),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res)
  );

  `CRPT_ASSERT(a_load_when_idle, (accept && (in_op == OP_LOAD)) |-> !busy)
  `CRPT_ASSERT(a_chain_holds, (out_valid && out_stall) |=> $stable(tail_vld))
  `CRPT_ASSERT(a_result_from_query, $rose(out_valid) |-> $past(tail_vld))
  `CRPT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid && !busy))

endmodule
